@@ hdl/scc_pkg.sv @@
package scc_pkg;

    localparam int FRAME_W   = 48;
    localparam int CRC_BYTES = FRAME_W / 8;

    localparam logic [7:0] CRC_POLY = 8'h2F;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    typedef enum logic [1:0] {
        ACT_READ  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_CHECK = 2'd2
    } action_t;

    // frame travels with its running crc through the byte stages
    typedef struct packed {
        action_t              action;
        logic [FRAME_W-1:0]   frame;
        logic [7:0]           crc;
    } scc_item_t;

    typedef struct packed {
        logic                 data_flag;
        logic [3:0]           data_count;
        logic [9:0]           reply_address;
        logic signed [19:0]   sensor_value;
        logic [1:0]           status;
        logic                 frame_valid;
        logic                 crc_ok;
        logic [FRAME_W-1:0]   tx_frame;
    } scc_result_t;

    // eight msb-first steps of the crc shift register
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                             input logic [7:0] data);
        logic [7:0] c;
        c = crc_in;
        for (int i = 7; i >= 0; i--) begin
            c = {c[6:0], data[i]} ^ (c[7] ? CRC_POLY : 8'h00);
        end
        return c;
    endfunction

endpackage

@@ hdl/sensor_spi_frame_codec.sv @@
// Builds read and write command frames for a sensor's 48-bit SPI link and
// checks received frames (crc-8, poly 0x2f, init 0xff, msb first, crc slot
// zeroed). One transaction is taken every cycle unless the output stalls;
// each passes through one frame assembly stage, six registered crc
// stages that each shift in one frame byte, and one decode/output stage.
// A stalled output holds the whole pipeline without loss.
module sensor_spi_frame_codec
    import scc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // address [9:0], write_data [29:10], rx_frame [77:30], zero [79:78]
    input  logic [79:0] s_tdata,
    // action [1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // tx_frame [47:0], crc_ok [48], frame_valid [49], status [51:50],
    // sensor_value [71:52], reply_address [81:72], data_count [85:82],
    // data_flag [86], zero [87]
    output logic [87:0] m_tdata
);

    logic        stg_valid [CRC_BYTES+1];
    logic        stg_ready [CRC_BYTES+1];
    scc_item_t   stg_item  [CRC_BYTES+1];
    scc_result_t result;

    scc_frame_asm u_asm (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .action     (action_t'(s_tuser)),
        .address    (s_tdata[9:0]),
        .write_data (s_tdata[29:10]),
        .rx_frame   (s_tdata[77:30]),
        .out_valid  (stg_valid[0]),
        .out_ready  (stg_ready[0]),
        .out_item   (stg_item[0])
    );

    // bytes go in msb first
    for (genvar g = 0; g < CRC_BYTES; g++) begin : g_crc
        scc_crc_stage #(
            .BYTE_IDX (CRC_BYTES - 1 - g)
        ) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (stg_valid[g]),
            .in_ready  (stg_ready[g]),
            .in_item   (stg_item[g]),
            .out_valid (stg_valid[g+1]),
            .out_ready (stg_ready[g+1]),
            .out_item  (stg_item[g+1])
        );
    end

    scc_decode u_decode (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (stg_valid[CRC_BYTES]),
        .in_ready   (stg_ready[CRC_BYTES]),
        .in_item    (stg_item[CRC_BYTES]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result)
    );

    assign m_tdata = {1'b0, result};

endmodule

@@ hdl/scc_frame_asm.sv @@
module scc_frame_asm
    import scc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  action_t            action,
    input  logic [9:0]         address,
    input  logic [19:0]        write_data,
    input  logic [FRAME_W-1:0] rx_frame,
    output logic               out_valid,
    input  logic               out_ready,
    output scc_item_t          out_item
);

    logic      valid_reg;
    scc_item_t item_reg;
    scc_item_t item_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_comb begin
        item_next.action = action;
        item_next.crc    = CRC_INIT;
        case (action)
            ACT_READ: begin
                item_next.frame = {address, 1'b0, 1'b0, 1'b1, 27'd0, 8'd0};
            end
            ACT_WRITE: begin
                item_next.frame = {address, 1'b1, 1'b0, 1'b1, 7'd0, write_data, 8'd0};
            end
            ACT_CHECK: begin
                item_next.frame = rx_frame;
            end
            default: begin
                item_next.frame = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= item_next;
        end
    end

endmodule

@@ hdl/scc_crc_stage.sv @@
module scc_crc_stage
    import scc_pkg::*;
#(
    parameter int BYTE_IDX = 0
)
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  scc_item_t in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output scc_item_t out_item
);

    logic      valid_reg;
    scc_item_t item_reg;
    scc_item_t item_next;
    logic [7:0] data_byte;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    // the crc slot itself is shifted in as zeros
    assign data_byte = (BYTE_IDX == 0) ? 8'h00 : in_item.frame[8*BYTE_IDX +: 8];

    always_comb begin
        item_next     = in_item;
        item_next.crc = crc8_byte(in_item.crc, data_byte);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= item_next;
        end
    end

endmodule

@@ hdl/scc_decode.sv @@
module scc_decode
    import scc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  scc_item_t   in_item,
    output logic        out_valid,
    input  logic        out_ready,
    output scc_result_t out_result
);

    logic        valid_reg;
    scc_result_t result_reg;
    scc_result_t result_next;
    logic        crc_match;

    assign in_ready   = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign out_result = result_reg;

    assign crc_match = (in_item.crc == in_item.frame[7:0]);

    always_comb begin
        result_next = '0;
        case (in_item.action)
            ACT_READ, ACT_WRITE: begin
                result_next.tx_frame = {in_item.frame[FRAME_W-1:8], in_item.crc};
            end
            ACT_CHECK: begin
                result_next.crc_ok        = crc_match;
                result_next.frame_valid   = crc_match && (in_item.frame[34:33] == 2'b00);
                result_next.status        = in_item.frame[34:33];
                result_next.sensor_value  = in_item.frame[27:8];
                result_next.reply_address = in_item.frame[46:37];
                result_next.data_count    = in_item.frame[32:29];
                result_next.data_flag     = in_item.frame[47];
            end
            default: begin
                result_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            result_reg <= result_next;
        end
    end

endmodule
